// File: src/tcgp_pkg.sv
`timescale 1ns / 1ps
package tcgp_pkg;

  localparam int TAB_STEP  = 32;
  localparam int TAB_SHIFT = $clog2(TAB_STEP);

  localparam logic [7:0] CHAR_BS     = 8'd8;
  localparam logic [7:0] CHAR_TAB    = 8'd9;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] GLYPH_FIRST = 8'd33;
  localparam logic [7:0] GLYPH_LAST  = 8'd127;

  localparam logic REG_GLYPH_WIDTH  = 1'b0;
  localparam logic REG_GLYPH_HEIGHT = 1'b1;

  localparam logic [6:0] GLYPH_WIDTH_RESET  = 7'd8;
  localparam logic [6:0] GLYPH_HEIGHT_RESET = 7'd16;

  typedef enum logic [2:0] {
    OP_SKIP,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_TAB,
    OP_SPACE,
    OP_GLYPH
  } tcgp_op_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        start_of_string;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } tcgp_in_t;

  typedef struct packed {
    logic [9:0]  atlas_x;
    logic [8:0]  atlas_y;
    logic [15:0] screen_x;
    logic [15:0] screen_y;
  } tcgp_out_t;

  typedef struct packed {
    tcgp_op_t    op;
    logic [3:0]  col;
    logic [3:0]  row;
    logic        start;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } tcgp_cmd_t;

endpackage

// File: src/tcgp_front.sv
`timescale 1ns / 1ps
module tcgp_front import tcgp_pkg::*; (
  input  tcgp_in_t  item,
  output tcgp_cmd_t cmd
);

  always_comb begin
    cmd.col      = item.char_code[3:0];
    cmd.row      = item.char_code[7:4];
    cmd.start    = item.start_of_string;
    cmd.origin_x = item.origin_x;
    cmd.origin_y = item.origin_y;
    case (item.char_code)
      CHAR_LF:    cmd.op = OP_NEWLINE;
      CHAR_CR:    cmd.op = OP_RETURN;
      CHAR_BS:    cmd.op = OP_BACKSPACE;
      CHAR_TAB:   cmd.op = OP_TAB;
      CHAR_SPACE: cmd.op = OP_SPACE;
      default: begin
        if (item.char_code inside {[GLYPH_FIRST:GLYPH_LAST]}) begin
          cmd.op = OP_GLYPH;
        end else begin
          cmd.op = OP_SKIP;
        end
      end
    endcase
  end

endmodule

// File: src/tcgp_queue.sv
`timescale 1ns / 1ps
module tcgp_queue import tcgp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tcgp_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output tcgp_cmd_t pop_data,
  output logic      not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  tcgp_cmd_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/tcgp_back.sv
`timescale 1ns / 1ps
module tcgp_back import tcgp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  tcgp_cmd_t cmd,
  output logic      cmd_pop,
  input  logic [6:0] glyph_width,
  input  logic [6:0] glyph_height,
  output logic      out_valid,
  input  logic      out_ready,
  output tcgp_out_t out_data
);

  logic [15:0] cursor_x_r, cursor_x_nxt;
  logic [15:0] cursor_y_r, cursor_y_nxt;
  logic [15:0] origin_r, origin_nxt;
  logic        out_valid_r, out_valid_nxt;
  tcgp_out_t   out_data_r;

  logic [15:0] cx, cy, lox;
  logic [15:0] adv_x, adv_y;
  logic [15:0] rel, quot, tab_off;
  logic [10:0] prod_x, prod_y;
  logic        slot_free, is_glyph;

  assign slot_free = !out_valid_r || out_ready;
  assign is_glyph  = (cmd.op == OP_GLYPH);
  assign cmd_pop   = cmd_valid && (!is_glyph || slot_free);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign adv_x  = 16'(glyph_width) + 16'd1;
  assign adv_y  = 16'(glyph_height) + 16'd1;
  assign prod_x = 11'(cmd.col) * 11'(glyph_width);
  assign prod_y = 11'(cmd.row) * 11'(glyph_height);

  always_comb begin
    cx  = cmd.start ? cmd.origin_x : cursor_x_r;
    cy  = cmd.start ? cmd.origin_y : cursor_y_r;
    lox = cmd.start ? cmd.origin_x : origin_r;
    rel = cx - lox;
    // Division by the tab step truncates toward zero.
    quot = 16'($signed(rel) >>> TAB_SHIFT);
    if (rel[15] && (rel[TAB_SHIFT-1:0] != '0)) begin
      quot = quot + 16'd1;
    end
    tab_off = 16'((quot + 16'd1) << TAB_SHIFT);

    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    origin_nxt    = origin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd_pop) begin
      cursor_x_nxt = cx;
      cursor_y_nxt = cy;
      origin_nxt   = lox;
      case (cmd.op)
        OP_NEWLINE: begin
          cursor_y_nxt = cy + adv_y;
          cursor_x_nxt = lox;
        end
        OP_RETURN:    cursor_x_nxt = lox;
        OP_BACKSPACE: cursor_x_nxt = cx - adv_x;
        OP_TAB:       cursor_x_nxt = lox + tab_off;
        OP_SPACE:     cursor_x_nxt = cx + adv_x;
        OP_GLYPH: begin
          cursor_x_nxt  = cx + adv_x;
          out_valid_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      origin_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      origin_r    <= origin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && is_glyph) begin
      out_data_r.atlas_x  <= prod_x[9:0];
      out_data_r.atlas_y  <= prod_y[8:0];
      out_data_r.screen_x <= cx;
      out_data_r.screen_y <= cy;
    end
  end

endmodule

// File: src/text_cursor_glyph_placer.sv
`timescale 1ns / 1ps
// Lays out a stream of character bytes into glyph placements.
// Input channel (in_valid, in_ready, in_data) takes one character word per
// cycle; a word with start_of_string set loads the cursor and line origin
// from its origin fields before the character is handled.
// Output channel (out_valid, out_ready, out_data) gives one word for each
// glyph code, 33 to 127: the atlas cell and the screen position of the glyph.
// Control codes move the cursor and other codes are dropped without output.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// glyph width (index 0) and glyph height (index 1); write only when idle.
// Throughput is one character per cycle while in_ready is high, set by the
// cursor update in the back end. A placement is registered twice on its way
// to the output: the accepted character is written into the command queue,
// and the back end takes it from the queue and loads the output register.
// When out_ready is low the output register holds its word; characters that
// give no output keep flowing, and a glyph waits in the queue, which fills
// and then drops in_ready.
// Synchronous reset clears the cursor and line origin to zero, empties the
// queue and output, and sets width 8 and height 16.
module text_cursor_glyph_placer import tcgp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tcgp_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output tcgp_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  logic [6:0] glyph_width_r, glyph_height_r;
  tcgp_cmd_t  front_cmd, queue_cmd;
  logic       queue_full, queue_valid, queue_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= GLYPH_WIDTH_RESET;
      glyph_height_r <= GLYPH_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data;
        REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcgp_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  tcgp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_data  (queue_cmd),
    .not_empty (queue_valid)
  );

  tcgp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (queue_valid),
    .cmd          (queue_cmd),
    .cmd_pop      (queue_pop),
    .glyph_width  (glyph_width_r),
    .glyph_height (glyph_height_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tcgp_pkg::*;

  class placement_board;
    logic [6:0]  glyph_w;
    logic [6:0]  glyph_h;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [15:0] line_x;
    tcgp_out_t   pending[$];
    int          chars_seen;
    int          glyphs_checked;
    int          errors;

    function new();
      glyph_w = GLYPH_WIDTH_RESET;
      glyph_h = GLYPH_HEIGHT_RESET;
      cur_x = '0;
      cur_y = '0;
      line_x = '0;
      chars_seen = 0;
      glyphs_checked = 0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [6:0] val);
      if (idx == REG_GLYPH_WIDTH) begin
        glyph_w = val;
      end else begin
        glyph_h = val;
      end
    endfunction

    // Advances the cursor for one accepted word and queues the placement it yields.
    function void note_char(tcgp_in_t c);
      logic [15:0] step_x;
      logic [15:0] step_y;
      logic [15:0] rel;
      int          tab_pos;
      tcgp_out_t   p;
      step_x = 16'(glyph_w) + 16'd1;
      step_y = 16'(glyph_h) + 16'd1;
      chars_seen++;
      if (c.start_of_string) begin
        cur_x = c.origin_x;
        cur_y = c.origin_y;
        line_x = c.origin_x;
      end
      if (c.char_code == CHAR_LF) begin
        cur_y = cur_y + step_y;
        cur_x = line_x;
      end else if (c.char_code == CHAR_CR) begin
        cur_x = line_x;
      end else if (c.char_code == CHAR_BS) begin
        cur_x = cur_x - step_x;
      end else if (c.char_code == CHAR_TAB) begin
        rel = cur_x - line_x;
        tab_pos = (int'($signed(rel)) / TAB_STEP + 1) * TAB_STEP;
        cur_x = 16'(tab_pos) + line_x;
      end else if (c.char_code == CHAR_SPACE) begin
        cur_x = cur_x + step_x;
      end else if (c.char_code >= GLYPH_FIRST && c.char_code <= GLYPH_LAST) begin
        p.atlas_x = 10'(int'(c.char_code[3:0]) * int'(glyph_w));
        p.atlas_y = 9'(int'(c.char_code[7:4]) * int'(glyph_h));
        p.screen_x = cur_x;
        p.screen_y = cur_y;
        pending.push_back(p);
        cur_x = cur_x + step_x;
      end
    endfunction

    function void check_placement(tcgp_out_t got);
      tcgp_out_t want;
      if (pending.size() == 0) begin
        $error("unexpected placement: atlas %0d,%0d screen %0d,%0d", got.atlas_x,
               got.atlas_y, $signed(got.screen_x), $signed(got.screen_y));
        errors++;
        return;
      end
      want = pending.pop_front();
      glyphs_checked++;
      if (got.atlas_x !== want.atlas_x) begin
        $error("atlas_x mismatch: expected %0d, got %0d", want.atlas_x, got.atlas_x);
        errors++;
      end
      if (got.atlas_y !== want.atlas_y) begin
        $error("atlas_y mismatch: expected %0d, got %0d", want.atlas_y, got.atlas_y);
        errors++;
      end
      if (got.screen_x !== want.screen_x) begin
        $error("screen_x mismatch: expected %0d, got %0d", $signed(want.screen_x),
               $signed(got.screen_x));
        errors++;
      end
      if (got.screen_y !== want.screen_y) begin
        $error("screen_y mismatch: expected %0d, got %0d", $signed(want.screen_y),
               $signed(got.screen_y));
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  tcgp_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  tcgp_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = REG_GLYPH_WIDTH;
  logic [6:0] cfg_data = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int settings_used = 1;

  placement_board board = new();

  text_cursor_glyph_placer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        board.check_placement(out_data);
      end
      if (in_valid && in_ready) begin
        board.note_char(in_data);
      end
      if (cfg_valid && cfg_ready) begin
        board.write_reg(cfg_index, cfg_data);
      end
    end
  end

  function automatic tcgp_in_t make_char(logic [7:0] code, logic start, logic [15:0] ox,
                                         logic [15:0] oy);
    tcgp_in_t c;
    c.char_code = code;
    c.start_of_string = start;
    c.origin_x = ox;
    c.origin_y = oy;
    return c;
  endfunction

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 8'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
    if (r < 70) return CHAR_SPACE;
    if (r < 75) return CHAR_LF;
    if (r < 80) return CHAR_CR;
    if (r < 86) return CHAR_BS;
    if (r < 93) return CHAR_TAB;
    return 8'($urandom_range(255));
  endfunction

  // Called just after a rising edge; returns at the edge where the word is taken.
  task automatic send_char(tcgp_in_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly whole strings with a start mark, with stray random words mixed in.
  task automatic send_random(int count);
    int sent;
    int len;
    logic [15:0] ox;
    logic [15:0] oy;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_char(make_char(8'($urandom_range(255)), 1'($urandom_range(1)),
                            16'($urandom()), 16'($urandom())));
        sent++;
      end else begin
        len = $urandom_range(1, 30);
        ox = pick_origin();
        oy = pick_origin();
        send_char(make_char(pick_code(), 1'b1, ox, oy));
        sent++;
        for (int i = 1; i < len && sent < count; i++) begin
          send_char(make_char(pick_code(), 1'b0, 16'($urandom()), 16'($urandom())));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int widths[8];
    int heights[8];
    widths = '{1, 64, 127, 0, 127, 0, 0, 0};
    heights = '{1, 64, 127, 0, 0, 127, 0, 0};
    widths[6] = $urandom_range(127);
    heights[6] = $urandom_range(127);
    widths[7] = $urandom_range(1, 64);
    heights[7] = $urandom_range(1, 64);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_char(make_char(8'd65, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(GLYPH_LAST, 1'b1, 16'h8000, 16'h7FFF));
    send_char(make_char(GLYPH_FIRST, 1'b0, 16'hFFFF, 16'hFFFF));
    send_char(make_char(CHAR_SPACE, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(8'd31, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(8'd0, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(8'd128, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(8'd255, 1'b0, 16'hFFFF, 16'hFFFF));
    send_char(make_char(CHAR_LF, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(CHAR_CR, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(CHAR_BS, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(CHAR_TAB, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(8'd90, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(CHAR_LF, 1'b1, 16'h7FFF, 16'hFFFF));
    send_char(make_char(8'd126, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(8'd0, 1'b1, 16'h0000, 16'h0000));
    send_char(make_char(CHAR_BS, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(CHAR_BS, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(CHAR_BS, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(CHAR_BS, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(CHAR_TAB, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(8'd112, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(8'd64, 1'b1, 16'h7FF0, 16'h8000));
    send_char(make_char(CHAR_TAB, 1'b0, 16'h0000, 16'h0000));
    send_char(make_char(GLYPH_FIRST, 1'b0, 16'h0000, 16'h0000));
    drain();

    for (int seg = 0; seg < 8; seg++) begin
      write_reg(REG_GLYPH_WIDTH, 7'(widths[seg]));
      write_reg(REG_GLYPH_HEIGHT, 7'(heights[seg]));
      cfg_valid <= 1'b0;
      settings_used++;
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 61;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 61;
        end
        default: begin
          send_idle_pct = 16;
          stall_pct = 16;
        end
      endcase
      send_random(235);
      drain();
    end

    $display("Laid out %0d character words under %0d glyph size settings.",
             board.chars_seen, settings_used);
    $display("Checked %0d glyph placements against the cursor predictor.",
             board.glyphs_checked);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out waiting for the block to finish.");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
src/tcgp_pkg.sv
src/tcgp_front.sv
src/tcgp_queue.sv
src/tcgp_back.sv
src/text_cursor_glyph_placer.sv
tb/tb_top.sv
